### sv/pfd_pkg.sv
// Shared types, constants and saturation helper for the polynomial
// finite-difference block. No dependencies.
package pfd_pkg;

   localparam int DATA_W = 32;
   localparam int DEG_W  = 4;
   localparam int IDX_IN_W = 4;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic    done;
      sat_type res;
   } unit_res_type;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_TOP_RD   = 9'b000000010,
      ST_TOP_LD   = 9'b000000100,
      ST_MUL_GO   = 9'b000001000,
      ST_MUL_WAIT = 9'b000010000,
      ST_PASS_END = 9'b000100000,
      ST_DIV_GO   = 9'b001000000,
      ST_DIV_WAIT = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   // Clamp a 33-bit two's complement value into 32 bits.
   function automatic sat_type sat_33(input logic signed [DATA_W:0] v);
      sat_type r;
      r.sat = (v[DATA_W] != v[DATA_W-1]);
      if (!r.sat) begin
         r.value = v[DATA_W-1:0];
      end else if (v[DATA_W]) begin
         r.value = Q_MIN;
      end else begin
         r.value = Q_MAX;
      end
      return r;
   endfunction

endpackage

### sv/polynomial_finite_difference.sv
// Polynomial finite-difference derivatives. Top level; depends on pfd_pkg, pfd_ram,
// pfd_mul and pfd_div.
//
// A load request (action 0) writes one Q16.16 coefficient and gives no response; the
// coefficient store reads as zero after reset. An evaluate request (action 1) runs
// Horner's rule at x0+h, x0 and x0-h on one shared two-stage multiplier, then runs three
// divisions on one restoring divider that yields one quotient bit per cycle. Its response
// holds the forward, central and backward differences in Q16.16, and the block returns to
// idle once the response register is free. A zero step skips the passes and divisions and
// returns zero differences with rsp_zero_step set. The block takes no request while an
// evaluation is under way, but accepts the next one while a finished response waits on
// rsp_ready. The degree register should only be written while the block is idle.
module polynomial_finite_difference #(
   parameter int MAX_TERMS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [pfd_pkg::IDX_IN_W-1:0]      req_coef_index,
   input  logic signed [pfd_pkg::DATA_W-1:0] req_coef_value,
   input  logic signed [pfd_pkg::DATA_W-1:0] req_point,
   input  logic signed [pfd_pkg::DATA_W-1:0] req_step,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pfd_pkg::DATA_W-1:0] rsp_forward_diff,
   output logic signed [pfd_pkg::DATA_W-1:0] rsp_central_diff,
   output logic signed [pfd_pkg::DATA_W-1:0] rsp_backward_diff,
   output logic                              rsp_zero_step,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  logic [pfd_pkg::DEG_W-1:0]         csr_wr_data
);

   import pfd_pkg::*;

   localparam int IDX_W = $clog2(MAX_TERMS);

   // Pass / division selector: plus, mid, minus for Horner; forward, central,
   // backward for the divisions.
   localparam logic [1:0] SEL_FIRST  = 2'd0;
   localparam logic [1:0] SEL_SECOND = 2'd1;
   localparam logic [1:0] SEL_THIRD  = 2'd2;

   state_type                state_ff, state_in;
   logic [DEG_W-1:0]         degree_ff;
   logic [MAX_TERMS-1:0]     vld_ff, vld_in;
   logic [IDX_W-1:0]         idx_ff, idx_in, deg_eff;
   logic [1:0]               sel_ff, sel_in;
   logic signed [DATA_W-1:0] x0_ff, x0_in, xp_ff, xp_in, xm_ff, xm_in, h_ff, h_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] pp_ff, pp_in, p0_ff, p0_in, pm_ff, pm_in;
   logic signed [DATA_W-1:0] fwd_ff, fwd_in, cen_ff, cen_in, bwd_ff, bwd_in;
   logic                     flag_ff, flag_in, zero_ff, zero_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] out_fwd_ff, out_cen_ff, out_bwd_ff;
   logic                     out_zero_ff, out_sat_ff;
   logic                     out_free, out_load;

   logic                     req_fire, load_fire, in_range;
   logic [IDX_W-1:0]         wr_addr;
   logic                     rd_en;
   logic [DATA_W-1:0]        rd_data;
   logic                     coef_vld_ff;
   logic signed [DATA_W-1:0] coef;

   sat_type                  xp_sat, xm_sat, add_sat;
   logic signed [DATA_W-1:0] x_cur;
   logic                     mul_start, div_start;
   unit_res_type             mul_res, div_res;
   logic signed [DATA_W:0]   div_num, div_den;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (32'(req_coef_index) < MAX_TERMS);
   assign wr_addr   = IDX_W'(req_coef_index);
   assign load_fire = req_fire && (req_action == ACT_LOAD) && in_range;

   assign deg_eff = (32'(degree_ff) > MAX_TERMS - 1) ? IDX_W'(MAX_TERMS - 1)
                                                     : IDX_W'(degree_ff);

   assign vld_in = vld_ff | (load_fire ? (MAX_TERMS'(1) << wr_addr) : '0);

   // Coefficient store
   assign rd_en = (state_ff == ST_TOP_RD) || (state_ff == ST_MUL_GO);

   pfd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_TERMS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (wr_addr),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Entries never loaded since reset read as zero.
   assign coef = coef_vld_ff ? rd_data : '0;

   // Shared arithmetic units
   always_comb begin
      case (sel_ff)
         SEL_FIRST:  x_cur = xp_ff;
         SEL_SECOND: x_cur = x0_ff;
         SEL_THIRD:  x_cur = xm_ff;
         default:    x_cur = x0_ff;
      endcase
   end

   assign mul_start = (state_ff == ST_MUL_GO);
   assign div_start = (state_ff == ST_DIV_GO);

   pfd_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (acc_ff),
      .b     (x_cur),
      .res   (mul_res)
   );

   always_comb begin
      case (sel_ff)
         SEL_FIRST: begin
            div_num = {pp_ff[DATA_W-1], pp_ff} - {p0_ff[DATA_W-1], p0_ff};
            div_den = {h_ff[DATA_W-1], h_ff};
         end
         SEL_SECOND: begin
            div_num = {pp_ff[DATA_W-1], pp_ff} - {pm_ff[DATA_W-1], pm_ff};
            div_den = {h_ff, 1'b0};
         end
         SEL_THIRD: begin
            div_num = {p0_ff[DATA_W-1], p0_ff} - {pm_ff[DATA_W-1], pm_ff};
            div_den = {h_ff[DATA_W-1], h_ff};
         end
         default: begin
            div_num = '0;
            div_den = {h_ff[DATA_W-1], h_ff};
         end
      endcase
   end

   pfd_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   assign xp_sat  = sat_33({req_point[DATA_W-1], req_point} + {req_step[DATA_W-1], req_step});
   assign xm_sat  = sat_33({req_point[DATA_W-1], req_point} - {req_step[DATA_W-1], req_step});
   assign add_sat = sat_33({mul_res.res.value[DATA_W-1], mul_res.res.value}
                           + {coef[DATA_W-1], coef});

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == ST_DONE) && out_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      x0_in    = x0_ff;
      xp_in    = xp_ff;
      xm_in    = xm_ff;
      h_in     = h_ff;
      acc_in   = acc_ff;
      pp_in    = pp_ff;
      p0_in    = p0_ff;
      pm_in    = pm_ff;
      fwd_in   = fwd_ff;
      cen_in   = cen_ff;
      bwd_in   = bwd_ff;
      flag_in  = flag_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_EVAL)) begin
               x0_in  = req_point;
               h_in   = req_step;
               xp_in  = xp_sat.value;
               xm_in  = xm_sat.value;
               idx_in = deg_eff;
               sel_in = SEL_FIRST;
               if (req_step == '0) begin
                  fwd_in   = '0;
                  cen_in   = '0;
                  bwd_in   = '0;
                  zero_in  = 1'b1;
                  flag_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  zero_in  = 1'b0;
                  flag_in  = xp_sat.sat || xm_sat.sat;
                  state_in = ST_TOP_RD;
               end
            end
         end
         ST_TOP_RD: begin
            state_in = ST_TOP_LD;
         end
         ST_TOP_LD: begin
            acc_in = coef;
            if (idx_ff == '0) begin
               state_in = ST_PASS_END;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_res.done) begin
               acc_in  = add_sat.value;
               flag_in = flag_ff || mul_res.res.sat || add_sat.sat;
               if (idx_ff == '0) begin
                  state_in = ST_PASS_END;
               end else begin
                  idx_in   = idx_ff - IDX_W'(1);
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_PASS_END: begin
            case (sel_ff)
               SEL_FIRST:  pp_in = acc_ff;
               SEL_SECOND: p0_in = acc_ff;
               default:    pm_in = acc_ff;
            endcase
            if (sel_ff == SEL_THIRD) begin
               sel_in   = SEL_FIRST;
               state_in = ST_DIV_GO;
            end else begin
               sel_in   = sel_ff + 2'd1;
               idx_in   = deg_eff;
               state_in = ST_TOP_RD;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               flag_in = flag_ff || div_res.res.sat;
               case (sel_ff)
                  SEL_FIRST:  fwd_in = div_res.res.value;
                  SEL_SECOND: cen_in = div_res.res.value;
                  default:    bwd_in = div_res.res.value;
               endcase
               if (sel_ff == SEL_THIRD) begin
                  state_in = ST_DONE;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DONE: begin
            // Hold until the response register is free.
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         degree_ff    <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            degree_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sel_ff  <= sel_in;
      x0_ff   <= x0_in;
      xp_ff   <= xp_in;
      xm_ff   <= xm_in;
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      pp_ff   <= pp_in;
      p0_ff   <= p0_in;
      pm_ff   <= pm_in;
      fwd_ff  <= fwd_in;
      cen_ff  <= cen_in;
      bwd_ff  <= bwd_in;
      flag_ff <= flag_in;
      zero_ff <= zero_in;
      if (rd_en) begin
         coef_vld_ff <= vld_ff[idx_ff];
      end
      if (out_load) begin
         out_fwd_ff  <= fwd_ff;
         out_cen_ff  <= cen_ff;
         out_bwd_ff  <= bwd_ff;
         out_zero_ff <= zero_ff;
         out_sat_ff  <= flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_diff  = out_fwd_ff;
   assign rsp_central_diff  = out_cen_ff;
   assign rsp_backward_diff = out_bwd_ff;
   assign rsp_zero_step     = out_zero_ff;
   assign rsp_saturated     = out_sat_ff;

endmodule

### sv/pfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pfd_mul.sv
// Two-stage fixed-point multiplier: signed product, then round to nearest
// (ties upward), drop the fraction and saturate. Depends on pfd_pkg.
module pfd_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pfd_pkg::DATA_W-1:0] a,
   input  logic signed [pfd_pkg::DATA_W-1:0] b,
   output pfd_pkg::unit_res_type             res
);

   import pfd_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam logic signed [PROD_W-1:0] HALF  = (PROD_W'(1) << FRAC_BITS) >> 1;
   localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'(Q_MAX);
   localparam logic signed [PROD_W-1:0] P_MIN = PROD_W'(Q_MIN);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] rnd;
   logic                     vld_ff, done_ff;
   sat_type                  sat_ff, sat_in;

   assign prod_in = a * b;

   always_comb begin
      rnd = (prod_ff + HALF) >>> FRAC_BITS;
      if (rnd > P_MAX) begin
         sat_in.sat   = 1'b1;
         sat_in.value = Q_MAX;
      end else if (rnd < P_MIN) begin
         sat_in.sat   = 1'b1;
         sat_in.value = Q_MIN;
      end else begin
         sat_in.sat   = 1'b0;
         sat_in.value = rnd[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= start;
         done_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
      if (vld_ff) begin
         sat_ff <= sat_in;
      end
   end

   assign res.done = done_ff;
   assign res.res  = sat_ff;

endmodule

### sv/pfd_div.sv
// Restoring divider, one quotient bit per cycle: (num * 2^FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits. Depends on pfd_pkg.
module pfd_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [pfd_pkg::DATA_W:0] num,
   input  logic signed [pfd_pkg::DATA_W:0] den,
   output pfd_pkg::unit_res_type           res
);

   import pfd_pkg::*;

   localparam int OP_W  = DATA_W + 1;
   localparam int NUM_W = OP_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(Q_MAX);
   localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(Q_MAX) + NUM_W'(1);

   logic [OP_W-1:0]  num_mag, den_mag;
   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [OP_W-1:0]  den_ff, rem_ff, rem_in;
   logic [OP_W:0]    rem_sh;
   logic             qbit;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, fin_ff, fin_in, done_ff;
   sat_type          out_ff, out_in;

   assign num_mag = num[OP_W-1] ? OP_W'(-num) : OP_W'(num);
   assign den_mag = den[OP_W-1] ? OP_W'(-den) : OP_W'(den);
   assign rem_sh  = {rem_ff, dvd_ff[NUM_W-1]};
   assign qbit    = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = NUM_W'(num_mag) << FRAC_BITS;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? OP_W'(rem_sh - {1'b0, den_ff}) : rem_sh[OP_W-1:0];
         dvd_in = {dvd_ff[NUM_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   // Apply the sign and clamp the quotient magnitude.
   always_comb begin
      if (!neg_ff && (dvd_ff > POS_LIM)) begin
         out_in.sat   = 1'b1;
         out_in.value = Q_MAX;
      end else if (neg_ff && (dvd_ff > NEG_LIM)) begin
         out_in.sat   = 1'b1;
         out_in.value = Q_MIN;
      end else begin
         out_in.sat   = 1'b0;
         out_in.value = neg_ff ? -dvd_ff[DATA_W-1:0] : dvd_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= den_mag;
         neg_ff <= num[OP_W-1] ^ den[OP_W-1];
      end
      if (fin_ff) begin
         out_ff <= out_in;
      end
   end

   assign res.done = done_ff;
   assign res.res  = out_ff;

endmodule
